@@ hdl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with search and
// replace: command and status codes, cell chain control word, sizes.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STS_W  = 3;

  localparam int IN_FIELDS_W  = CMD_W + 2 * DATA_W;
  localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STS_W + DATA_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REPLACE    = 3'd4,
    CMD_DUMP_FWD   = 3'd5,
    CMD_DUMP_BWD   = 3'd6
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 3'd0,
    STS_EMPTY    = 3'd1,
    STS_FULL     = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_BADCMD   = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHL,
    CELL_SHR,
    CELL_WRITE
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t               mode;
    logic [IDX_W-1:0]         widx;
    logic                     head_fill;
    logic                     tail_fill;
    logic signed [DATA_W-1:0] fill;
  } chain_ctrl_t;

endpackage

@@ hdl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the entry chain. It holds, takes its left or right
// neighbor's word, or is written when its position is addressed.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                              clk,
  input  deq_pkg::chain_ctrl_t              ctrl,
  input  logic [deq_pkg::IDX_W-1:0]         idx,
  input  logic signed [deq_pkg::DATA_W-1:0] left_in,
  input  logic signed [deq_pkg::DATA_W-1:0] right_in,
  output logic signed [deq_pkg::DATA_W-1:0] q
);
  import deq_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.mode)
      CELL_SHL: q <= right_in;
      CELL_SHR: q <= left_in;
      CELL_WRITE: begin
        if (ctrl.widx == idx) begin
          q <= ctrl.fill;
        end
      end
      default: q <= q;
    endcase
  end

endmodule

@@ hdl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: decodes commands, keeps the occupancy, steps the cell
// chain through full rotations for replace and dump, and holds the output word.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [deq_pkg::IN_W-1:0]          s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [deq_pkg::OUT_W-1:0]         m_tdata,
  output logic                              m_tlast,
  input  logic signed [deq_pkg::DATA_W-1:0] head_q,
  input  logic signed [deq_pkg::DATA_W-1:0] tail_q,
  output deq_pkg::chain_ctrl_t              chain
);
  import deq_pkg::*;

  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(DEPTH - 1);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         occ, occ_next;
  logic [IDX_W-1:0]         k, k_next;
  logic                     found, found_next;
  cmd_t                     op, op_next;
  logic signed [DATA_W-1:0] val, val_next;
  logic signed [DATA_W-1:0] nval, nval_next;

  logic                     out_valid, out_valid_next;
  status_t                  out_status, out_status_next;
  logic signed [DATA_W-1:0] out_data, out_data_next;
  logic                     out_last, out_last_next;

  cmd_t                     in_cmd;
  logic signed [DATA_W-1:0] in_val;
  logic signed [DATA_W-1:0] in_nval;
  logic                     out_free;
  logic                     in_fire;
  logic                     is_full;
  logic                     is_empty;
  logic                     k_in_occ;
  logic                     k_in_tail;
  logic                     k_is_last;
  logic                     hit;
  logic [CNT_W:0]           k_plus_occ;

  assign in_cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
  assign in_val  = s_tdata[CMD_W +: DATA_W];
  assign in_nval = s_tdata[CMD_W + DATA_W +: DATA_W];

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;

  assign is_full    = (occ == CNT_W'(DEPTH));
  assign is_empty   = (occ == '0);
  assign k_in_occ   = ({{(CNT_W-IDX_W){1'b0}}, k} < occ);
  assign k_plus_occ = {{(CNT_W+1-IDX_W){1'b0}}, k} + {1'b0, occ};
  assign k_in_tail  = (k_plus_occ >= (CNT_W+1)'(DEPTH));
  assign k_is_last  = (k == K_LAST);
  assign hit        = k_in_occ && !found && (head_q == val);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && !is_empty && (in_cmd == CMD_REPLACE || in_cmd == CMD_DUMP_FWD ||
                                     in_cmd == CMD_DUMP_BWD)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (out_free && k_is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    occ_next        = occ;
    k_next          = k;
    found_next      = found;
    op_next         = op;
    val_next        = val;
    nval_next       = nval;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_last_next   = out_last;
    chain.mode      = CELL_HOLD;
    chain.widx      = occ[IDX_W-1:0];
    chain.head_fill = 1'b0;
    chain.tail_fill = 1'b0;
    chain.fill      = in_val;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_next  = 1'b1;
          out_status_next = STS_OK;
          out_data_next   = '0;
          out_last_next   = 1'b1;
          op_next         = in_cmd;
          val_next        = in_val;
          nval_next       = in_nval;
          k_next          = '0;
          found_next      = 1'b0;
          case (in_cmd)
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                out_status_next = STS_FULL;
              end else begin
                chain.mode      = CELL_SHR;
                chain.head_fill = 1'b1;
                occ_next        = occ + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                out_status_next = STS_FULL;
              end else begin
                chain.mode = CELL_WRITE;
                occ_next   = occ + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                out_status_next = STS_EMPTY;
              end else begin
                chain.mode = CELL_SHL;
                occ_next   = occ - 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                out_status_next = STS_EMPTY;
              end else begin
                occ_next = occ - 1'b1;
              end
            end
            CMD_REPLACE, CMD_DUMP_FWD, CMD_DUMP_BWD: begin
              out_valid_next = is_empty;
              out_status_next = STS_EMPTY;
            end
            default: out_status_next = STS_BADCMD;
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          k_next     = k + 1'b1;
          chain.fill = nval;
          case (op)
            CMD_DUMP_BWD: begin
              chain.mode = CELL_SHR;
              if (k_in_tail) begin
                out_valid_next  = 1'b1;
                out_status_next = STS_OK;
                out_data_next   = tail_q;
                out_last_next   = k_is_last;
              end
            end
            CMD_DUMP_FWD: begin
              chain.mode = CELL_SHL;
              if (k_in_occ) begin
                out_valid_next  = 1'b1;
                out_status_next = STS_OK;
                out_data_next   = head_q;
                out_last_next   = ({{(CNT_W-IDX_W){1'b0}}, k} + 1'b1 == occ);
              end
            end
            default: begin
              chain.mode      = CELL_SHL;
              chain.tail_fill = hit;
              found_next      = found || hit;
              if (k_is_last) begin
                out_valid_next  = 1'b1;
                out_status_next = (found || hit) ? STS_OK : STS_NOTFOUND;
                out_data_next   = '0;
                out_last_next   = 1'b1;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    found      <= found_next;
    op         <= op_next;
    val        <= val_next;
    nval       <= nval_next;
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_W-OUT_FIELDS_W){1'b0}}, out_data, out_status};

endmodule

@@ hdl/deque_with_search_replace.sv @@
// ----------------------------------------------------------------------------
// Push and pop are done when the command word is taken; their status word is
// valid in the next cycle. On a non-empty queue, replace and dump rotate the
// whole chain of DEPTH cells, one position per cycle while the output is not
// stalled, and no new command word is taken until the rotation is done.
// Reset is synchronous: it empties the queue and drops the output word;
// the cells themselves are not cleared.
// ----------------------------------------------------------------------------
// deque_with_search_replace
// Bounded double-ended queue of signed words kept in a chain of shift cells,
// front entry in the first cell, with search-and-replace and dump commands.
// ----------------------------------------------------------------------------
module deque_with_search_replace (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [deq_pkg::IN_W-1:0]  s_tdata,   // command, value, new_value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [deq_pkg::OUT_W-1:0] m_tdata,   // status, data_out
  output logic                      m_tlast
);
  import deq_pkg::*;

  chain_ctrl_t              chain;
  logic signed [DATA_W-1:0] q        [DEPTH];
  logic signed [DATA_W-1:0] left_in  [DEPTH];
  logic signed [DATA_W-1:0] right_in [DEPTH];

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .head_q   (q[0]),
    .tail_q   (q[DEPTH-1]),
    .chain    (chain)
  );

  assign left_in[0]        = chain.head_fill ? chain.fill : q[DEPTH-1];
  assign right_in[DEPTH-1] = chain.tail_fill ? chain.fill : q[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_left
      assign left_in[i] = q[i-1];
    end
    if (i < DEPTH - 1) begin : g_right
      assign right_in[i] = q[i+1];
    end
    deq_cell u_cell (
      .clk      (clk),
      .ctrl     (chain),
      .idx      (IDX_W'(i)),
      .left_in  (left_in[i]),
      .right_in (right_in[i]),
      .q        (q[i])
    );
  end

endmodule

@@ hdl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [deq_pkg::IN_W-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [deq_pkg::OUT_W-1:0] m_tdata,
  input logic                      m_tlast
);
  import deq_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
    else $error("waiting input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STS_W-1:0] != STS_OK) |->
      m_tlast && (m_tdata[STS_W +: DATA_W] == '0))
    else $error("error status word must be last and carry zero data");

  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input taken while output word is blocked");

endmodule

bind deque_with_search_replace deq_checker u_deq_checker (.*);
